/* hw/rtl/pce_pkg.sv */
// Shared types, codes and defaults for the piecewise cubic evaluator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package pce_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int PADDR_W        = 4;

    typedef enum logic [1:0] {
        OP_WR_BP   = 2'd0,
        OP_WR_COEF = 2'd1,
        OP_QUERY   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_ORDER  = 2'd0,
        REG_EXTRAP = 2'd1,
        REG_POINTS = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [2:0] derivative_order;
        logic       extrapolate_enable;
        logic [8:0] point_count;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               clip;
    } sat_t;

    function automatic sat_t sat32(input logic signed [66:0] v);
        sat_t r;
        r.clip  = 1'b0;
        r.value = v[31:0];
        if (v > 67'sd2147483647) begin
            r.clip  = 1'b1;
            r.value = 32'sh7fffffff;
        end else if (v < -67'sd2147483648) begin
            r.clip  = 1'b1;
            r.value = 32'sh80000000;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/pce_regs.sv */
// Configuration register file on the APB-style port.
// Depends on pce_pkg for the register codes and the configuration struct.
`timescale 1ns / 1ps
module pce_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pce_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output pce_pkg::cfg_t              cfg
);

    pce_pkg::cfg_t    cfg_reg;
    pce_pkg::cfg_t    cfg_next;
    pce_pkg::reg_idx_t sel;

    assign sel    = pce_pkg::reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (sel)
                pce_pkg::REG_ORDER:  cfg_next.derivative_order   = pwdata[2:0];
                pce_pkg::REG_EXTRAP: cfg_next.extrapolate_enable = pwdata[0];
                pce_pkg::REG_POINTS: cfg_next.point_count        = pwdata[8:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            pce_pkg::REG_ORDER:  prdata = {29'd0, cfg_reg.derivative_order};
            pce_pkg::REG_EXTRAP: prdata = {31'd0, cfg_reg.extrapolate_enable};
            pce_pkg::REG_POINTS: prdata = {23'd0, cfg_reg.point_count};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.derivative_order   <= 3'd0;
            cfg_reg.extrapolate_enable <= 1'b1;
            cfg_reg.point_count        <= 9'd2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hw/rtl/pce_mem.sv */
// Breakpoint and coefficient memories, one write and one registered read port each.
// Depends on pce_pkg for its default size; sized by the breakpoint count handed down from the top level.
`timescale 1ns / 1ps
module pce_mem #(
    parameter int MaxPoints = pce_pkg::MAX_POINTS_DEF
) (
    input  logic                         clk,
    input  logic                         bp_we,
    input  logic [$clog2(MaxPoints)-1:0] bp_waddr,
    input  logic [31:0]                  bp_wdata,
    input  logic [$clog2(MaxPoints)-1:0] bp_raddr,
    output logic [31:0]                  bp_rdata,
    input  logic                         coef_we,
    input  logic [$clog2(MaxPoints)+1:0] coef_waddr,
    input  logic [31:0]                  coef_wdata,
    input  logic [$clog2(MaxPoints)+1:0] coef_raddr,
    output logic [31:0]                  coef_rdata
);

    logic [31:0] bp_mem   [MaxPoints];
    logic [31:0] coef_mem [4*MaxPoints];

    always_ff @(posedge clk)
    begin
        if (bp_we)
        begin
            bp_mem[bp_waddr] <= bp_wdata;
        end
        bp_rdata <= bp_mem[bp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        coef_rdata <= coef_mem[coef_raddr];
    end

endmodule

/* hw/rtl/pce_core.sv */
// Sequencer and Horner datapath: table writes, range check, piece search, evaluation.
// Depends on pce_pkg; drives the memories in pce_mem.
`timescale 1ns / 1ps
module pce_core #(
    parameter int MaxPoints = pce_pkg::MAX_POINTS_DEF,
    parameter int FracBits  = pce_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pce_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   operation,
    input  logic [7:0]                   entry_index,
    input  logic [1:0]                   coeff_slot,
    input  logic signed [31:0]           data_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [31:0]           result_value,
    output logic                         out_of_range,
    output logic                         saturated,
    output logic                         bp_we,
    output logic [$clog2(MaxPoints)-1:0] bp_waddr,
    output logic [31:0]                  bp_wdata,
    output logic [$clog2(MaxPoints)-1:0] bp_raddr,
    input  logic signed [31:0]           bp_rdata,
    output logic                         coef_we,
    output logic [$clog2(MaxPoints)+1:0] coef_waddr,
    output logic [31:0]                  coef_wdata,
    output logic [$clog2(MaxPoints)+1:0] coef_raddr,
    input  logic signed [31:0]           coef_rdata
);

    localparam int AW = $clog2(MaxPoints);
    localparam logic signed [65:0] HALF = 66'sd1 <<< FracBits >>> 1;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_CHK0 = 10'b0000000010,
        ST_CHK1 = 10'b0000000100,
        ST_CHK2 = 10'b0000001000,
        ST_SCAN = 10'b0000010000,
        ST_BASE = 10'b0000100000,
        ST_COEF = 10'b0001000000,
        ST_INIT = 10'b0010000000,
        ST_MUL  = 10'b0100000000,
        ST_ADD  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic                  done_reg, done_next;
    logic signed [31:0]    x_reg, x_next;
    logic signed [32:0]    d_reg, d_next;
    logic signed [31:0]    c_reg [4];
    logic signed [31:0]    c_next [4];
    logic signed [31:0]    acc_reg, acc_next;
    logic signed [64:0]    prod_reg, prod_next;
    logic [1:0]            stage_reg, stage_next;
    logic [AW-1:0]         piece_reg, piece_next;
    logic [AW-1:0]         k_reg, k_next;
    logic                  lo_fail_reg, lo_fail_next;
    logic                  oor_reg, oor_next;
    logic                  clip_reg, clip_next;

    logic                  out_valid_reg, out_valid_next;
    logic signed [31:0]    result_reg, result_next;
    logic                  oor_out_reg, oor_out_next;
    logic                  sat_out_reg, sat_out_next;

    logic [31:0]           pc_ext, n_full, n_m1, n_m2, idx_ext;
    logic                  linear, idx_ok, accept, zero_case, hi_fail;
    logic [2:0]            ord;
    logic [1:0]            last_stage;
    logic signed [66:0]    c0_ext, init_val, sum_val;
    logic signed [65:0]    shifted;
    logic signed [33:0]    addend;
    pce_pkg::sat_t         sat_init, sat_sum;

    assign pc_ext  = 32'(cfg.point_count);
    assign n_full  = (pc_ext < 32'd2) ? 32'd2 :
                     ((pc_ext > 32'(MaxPoints)) ? 32'(MaxPoints) : pc_ext);
    assign n_m1    = n_full - 32'd1;
    assign n_m2    = n_full - 32'd2;
    assign linear  = (n_full == 32'd2);
    assign ord     = cfg.derivative_order;
    assign idx_ext = 32'(entry_index);
    assign idx_ok  = (idx_ext < 32'(MaxPoints));

    assign in_ready  = (state_reg == ST_IDLE) && !done_reg;
    assign accept    = in_valid && in_ready;
    assign zero_case = (ord > 3'd3) || (linear && ord >= 3'd2);
    assign hi_fail   = (x_reg > bp_rdata);
    assign last_stage = 2'(3'd3 - ord);

    assign bp_we      = accept && (operation == pce_pkg::OP_WR_BP) && idx_ok;
    assign bp_waddr   = idx_ext[AW-1:0];
    assign bp_wdata   = data_value;
    assign coef_we    = accept && (operation == pce_pkg::OP_WR_COEF) && idx_ok;
    assign coef_waddr = {idx_ext[AW-1:0], coeff_slot};
    assign coef_wdata = data_value;

    assign c0_ext   = 67'(c_reg[0]);
    assign init_val = (ord == 3'd0) ? c0_ext :
                      ((ord == 3'd1) ? (c0_ext + (c0_ext <<< 1))
                                     : ((c0_ext + (c0_ext <<< 1)) <<< 1));
    assign sat_init = pce_pkg::sat32(init_val);

    assign addend   = ((stage_reg == 2'd1) && (ord != 3'd0)) ?
                      (34'(c_reg[stage_reg]) <<< 1) : 34'(c_reg[stage_reg]);
    assign shifted  = (66'(prod_reg) + HALF) >>> FracBits;
    assign sum_val  = 67'(shifted) + 67'(addend);
    assign sat_sum  = pce_pkg::sat32(sum_val);

    always_comb
    begin
        bp_raddr   = '0;
        coef_raddr = '0;
        case (state_reg)
            ST_CHK0: bp_raddr = '0;
            ST_CHK1: bp_raddr = n_m1[AW-1:0];
            ST_CHK2: bp_raddr = AW'(1);
            ST_SCAN: bp_raddr = k_reg + AW'(1);
            ST_BASE:
            begin
                bp_raddr   = piece_reg;
                coef_raddr = {piece_reg, 2'd0};
            end
            ST_COEF: coef_raddr = {piece_reg, stage_reg + 2'd1};
            default:
            begin
                bp_raddr   = '0;
                coef_raddr = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        done_next    = done_reg;
        x_next       = x_reg;
        d_next       = d_reg;
        c_next       = c_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        stage_next   = stage_reg;
        piece_next   = piece_reg;
        k_next       = k_reg;
        lo_fail_next = lo_fail_reg;
        oor_next     = oor_reg;
        clip_next    = clip_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == pce_pkg::OP_QUERY))
                begin
                    x_next    = data_value;
                    oor_next  = 1'b0;
                    clip_next = 1'b0;
                    acc_next  = '0;
                    if (zero_case)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_CHK0;
                    end
                end
            end
            ST_CHK0:
            begin
                state_next = ST_CHK1;
            end
            ST_CHK1:
            begin
                lo_fail_next = (x_reg < bp_rdata);
                state_next   = ST_CHK2;
            end
            ST_CHK2:
            begin
                piece_next = '0;
                k_next     = AW'(1);
                if (!cfg.extrapolate_enable && (lo_fail_reg || hi_fail))
                begin
                    oor_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (linear)
                begin
                    state_next = ST_BASE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (bp_rdata <= x_reg)
                begin
                    piece_next = piece_reg + AW'(1);
                end
                k_next = k_reg + AW'(1);
                if (k_reg == n_m2[AW-1:0])
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                stage_next = 2'd0;
                state_next = ST_COEF;
            end
            ST_COEF:
            begin
                if (stage_reg == 2'd0)
                begin
                    d_next = 33'(x_reg) - 33'(bp_rdata);
                end
                c_next[stage_reg] = (linear && !stage_reg[1]) ? 32'sd0 : coef_rdata;
                stage_next = stage_reg + 2'd1;
                if (stage_reg == 2'd3)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                acc_next   = sat_init.value;
                clip_next  = sat_init.clip;
                stage_next = 2'd1;
                if (ord == 3'd3)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = 65'(acc_reg) * 65'(d_reg);
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                acc_next   = sat_sum.value;
                clip_next  = clip_reg | sat_sum.clip;
                stage_next = stage_reg + 2'd1;
                if (stage_reg == last_stage)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (done_reg && (!out_valid_reg || out_ready))
        begin
            done_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        oor_out_next   = oor_out_reg;
        sat_out_next   = sat_out_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (done_reg && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
            result_next    = acc_reg;
            oor_out_next   = oor_reg;
            sat_out_next   = clip_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign out_of_range = oor_out_reg;
    assign saturated    = sat_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        d_reg       <= d_next;
        c_reg       <= c_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        stage_reg   <= stage_next;
        piece_reg   <= piece_next;
        k_reg       <= k_next;
        lo_fail_reg <= lo_fail_next;
        oor_reg     <= oor_next;
        clip_reg    <= clip_next;
        result_reg  <= result_next;
        oor_out_reg <= oor_out_next;
        sat_out_reg <= sat_out_next;
    end

endmodule

/* hw/rtl/piecewise_cubic_evaluator_top.sv */
// Top level of the piecewise cubic evaluator: register port, memories and core.
// Depends on pce_pkg, pce_regs, pce_mem and pce_core.
`timescale 1ns / 1ps
// Table writes (breakpoint or coefficient) are accepted when in_ready is high.
// A query whose derivative is identically zero ends at once, one that falls
// out of range ends after the range check, and any other runs the piece
// search (skipped in linear mode), which reads the breakpoint memory one
// entry per cycle, then brings the four coefficients through the single
// coefficient read port, and each Horner step shares one multiplier over a
// multiply and an add state. The output register lets the next item enter
// while a result waits to be taken.
module piecewise_cubic_evaluator_top #(
    parameter int MaxPoints = pce_pkg::MAX_POINTS_DEF,
    parameter int FracBits  = pce_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [7:0]                  entry_index,
    input  logic [1:0]                  coeff_slot,
    input  logic signed [31:0]          data_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [31:0]          result_value,
    output logic                        out_of_range,
    output logic                        saturated,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pce_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int AW = $clog2(MaxPoints);

    pce_pkg::cfg_t cfg;
    logic          bp_we, coef_we;
    logic [AW-1:0] bp_waddr, bp_raddr;
    logic [AW+1:0] coef_waddr, coef_raddr;
    logic [31:0]   bp_wdata, bp_rdata, coef_wdata, coef_rdata;

    pce_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pce_mem #(
        .MaxPoints (MaxPoints)
    ) u_mem (
        .clk        (clk),
        .bp_we      (bp_we),
        .bp_waddr   (bp_waddr),
        .bp_wdata   (bp_wdata),
        .bp_raddr   (bp_raddr),
        .bp_rdata   (bp_rdata),
        .coef_we    (coef_we),
        .coef_waddr (coef_waddr),
        .coef_wdata (coef_wdata),
        .coef_raddr (coef_raddr),
        .coef_rdata (coef_rdata)
    );

    pce_core #(
        .MaxPoints (MaxPoints),
        .FracBits  (FracBits)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .entry_index  (entry_index),
        .coeff_slot   (coeff_slot),
        .data_value   (data_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .out_of_range (out_of_range),
        .saturated    (saturated),
        .bp_we        (bp_we),
        .bp_waddr     (bp_waddr),
        .bp_wdata     (bp_wdata),
        .bp_raddr     (bp_raddr),
        .bp_rdata     (bp_rdata),
        .coef_we      (coef_we),
        .coef_waddr   (coef_waddr),
        .coef_wdata   (coef_wdata),
        .coef_raddr   (coef_raddr),
        .coef_rdata   (coef_rdata)
    );

endmodule

/* hw/rtl/pce_checker.sv */
// Port-level checks for the piecewise cubic evaluator, bound to the top level.
// Depends on pce_pkg and piecewise_cubic_evaluator_top.
`timescale 1ns / 1ps
module pce_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [1:0]        operation,
    input logic              out_valid,
    input logic              out_ready,
    input logic signed [31:0] result_value,
    input logic              out_of_range,
    input logic              saturated,
    input logic              pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before it was taken");

    a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> !saturated && (result_value == 32'sd0))
        else $error("out-of-range beat carries a value or a clip flag");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operation == pce_pkg::OP_QUERY) |=> !in_ready)
        else $error("a new beat was taken while a query was in flight");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("register port stalled");

endmodule

bind piecewise_cubic_evaluator_top pce_checker u_pce_checker (.*);
